[src/zsp_pkg.sv]
// zsp_pkg: types, constants and frame check functions for the zmodem subpacket encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package zsp_pkg;

    localparam logic [7:0] ZDLE_CHAR     = 8'h18;
    localparam logic [7:0] XON_CHAR      = 8'h11;
    localparam logic [7:0] FE_BASE_CHAR  = 8'h68;
    localparam logic [7:0] ESC_FLIP      = 8'h40;
    localparam logic [1:0] FE_ZCRCW      = 2'd3;
    localparam logic [31:0] CRC32_POLY   = 32'hEDB88320;
    localparam logic [15:0] CRC16_POLY   = 16'h1021;
    localparam logic [31:0] CRC32_INIT   = 32'hFFFFFFFF;
    localparam int ZSP_QUEUE_DEPTH       = 2;

    // crc byte index: 32-bit check sends four, 16-bit sends two
    localparam logic [1:0] CRC32_LAST_IDX = 2'd3;
    localparam logic [1:0] CRC16_LAST_IDX = 2'd1;

    typedef enum logic [2:0] {
        PH_DATA,
        PH_ZDLE,
        PH_FE,
        PH_CRC,
        PH_XON
    } phase_t;

    typedef struct packed {
        logic        has_data;
        logic [7:0]  data_byte;
        logic        is_last;
        logic [1:0]  frame_end;
        logic        crc32_mode;
        logic [31:0] crc_out;
    } job_t;

    function automatic logic needs_escape(input logic [7:0] b);
        logic [6:0] low;
        low = b[6:0];
        return (low == 7'h10) || (low == 7'h11) || (low == 7'h13) || (low == 7'h18);
    endfunction

    function automatic logic [31:0] crc32_fold(input logic [31:0] crc_in,
                                               input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC32_POLY : 32'h0);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_fold(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = {c[14:0], 1'b0} ^ (c[15] ? CRC16_POLY : 16'h0);
        end
        return c;
    endfunction

    function automatic logic [31:0] crc_fold(input logic mode32,
                                             input logic [31:0] crc_in,
                                             input logic [7:0] b);
        if (mode32) begin
            return crc32_fold(crc_in, b);
        end else begin
            return {16'h0, crc16_fold(crc_in[15:0], b)};
        end
    endfunction

endpackage

`default_nettype wire

[src/zmodem_subpacket_encoder.sv]
// zmodem_subpacket_encoder: top level, config register and front/queue/back wiring
// depends on zsp_pkg, zsp_front, zsp_queue, zsp_back
`timescale 1ns / 1ps
`default_nettype none

// ZMODEM binary data subpacket encoder. One input transfer carries one payload byte
// (or none) and may close the packet; the block sends the byte ZDLE-escaped, and on
// close sends ZDLE, the frame-end character, the escaped CRC and XON after ZCRCW.
// The front end takes an item when the queue is not full and folds it into the CRC; a
// job queue of QUEUE_DEPTH entries feeds the back end, which sends one line byte per
// cycle from its output register while a job is queued and m_ready does not stall it.
// An item yields 1 or 2 line bytes for a payload byte, up to 13 for a closing item; an
// empty item yields no byte and is not queued. The user must write use_crc32 through
// cfg_we/cfg_wdata only while the block is idle; the block itself does not enforce it.

module zmodem_subpacket_encoder
    import zsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = ZSP_QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_data_valid,
    input  wire logic       s_last_of_packet,
    input  wire logic [1:0] s_frame_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);

    logic use_crc32_reg;
    logic q_full, q_push, q_pop, q_head_valid;
    job_t q_push_job, q_head_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_crc32_reg <= 1'b0;
        end else if (cfg_we) begin
            use_crc32_reg <= cfg_wdata;
        end
    end

    zsp_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .use_crc32        (use_crc32_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_data_valid     (s_data_valid),
        .s_last_of_packet (s_last_of_packet),
        .s_frame_end      (s_frame_end),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_job            (q_push_job)
    );

    zsp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (q_head_job)
    );

    zsp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_head_valid),
        .head_job      (q_head_job),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

[src/zsp_front.sv]
// zsp_front: accepts input items, runs the frame check and builds a job for each non-empty item
// depends on zsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module zsp_front
    import zsp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       use_crc32,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_data_valid,
    input  wire logic       s_last_of_packet,
    input  wire logic [1:0] s_frame_end,
    input  wire logic       q_full,
    output logic            q_push,
    output job_t            q_job
);

    logic [31:0] crc_reg, crc_next;
    logic        open_reg, open_next;
    logic [31:0] crc_init, crc_data, crc_fe;
    logic [7:0]  fe_char;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign fe_char = FE_BASE_CHAR + {6'h0, s_frame_end};

    always_comb begin
        crc_init = open_reg ? crc_reg : (use_crc32 ? CRC32_INIT : 32'h0);
        crc_data = s_data_valid ? crc_fold(use_crc32, crc_init, s_data_byte) : crc_init;
        crc_fe   = s_last_of_packet ? crc_fold(use_crc32, crc_data, fe_char) : crc_data;
        crc_next  = crc_reg;
        open_next = open_reg;
        if (accept) begin
            crc_next  = crc_fe;
            open_next = !s_last_of_packet;
        end
    end

    always_comb begin
        q_push            = accept && (s_data_valid || s_last_of_packet);
        q_job.has_data    = s_data_valid;
        q_job.data_byte   = s_data_byte;
        q_job.is_last     = s_last_of_packet;
        q_job.frame_end   = s_frame_end;
        q_job.crc32_mode  = use_crc32;
        q_job.crc_out     = use_crc32 ? ~crc_fe : {16'h0, crc_fe[15:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg  <= 32'h0;
            open_reg <= 1'b0;
        end else begin
            crc_reg  <= crc_next;
            open_reg <= open_next;
        end
    end

endmodule

`default_nettype wire

[src/zsp_queue.sv]
// zsp_queue: short job queue between the front and the back end
// depends on zsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module zsp_queue
    import zsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = ZSP_QUEUE_DEPTH
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output job_t      head_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

[src/zsp_back.sv]
// zsp_back: byte sequencer that turns jobs into escaped line bytes, output register
// depends on zsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module zsp_back
    import zsp_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic head_valid,
    input  wire job_t head_job,
    output logic      pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run
);

    phase_t     phase_reg, phase_next, cur_phase;
    logic       esc_reg, esc_next;
    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic [7:0] raw_byte, crc_byte, emit_byte;
    logic [1:0] last_idx;
    logic       step_done, run_end, fire;

    assign fire    = head_valid && (!m_valid_reg || m_ready);
    assign pop     = fire && run_end;
    assign last_idx = head_job.crc32_mode ? CRC32_LAST_IDX : CRC16_LAST_IDX;

    // a job without data always closes a packet
    assign cur_phase = (phase_reg == PH_DATA && !head_job.has_data) ? PH_ZDLE : phase_reg;

    always_comb begin
        if (head_job.crc32_mode) begin
            case (idx_reg)
                2'd0:    crc_byte = head_job.crc_out[7:0];
                2'd1:    crc_byte = head_job.crc_out[15:8];
                2'd2:    crc_byte = head_job.crc_out[23:16];
                default: crc_byte = head_job.crc_out[31:24];
            endcase
        end else begin
            crc_byte = idx_reg[0] ? head_job.crc_out[7:0] : head_job.crc_out[15:8];
        end
    end

    // outputs of the sequencer
    always_comb begin
        unique case (cur_phase)
            PH_DATA: raw_byte = head_job.data_byte;
            PH_ZDLE: raw_byte = ZDLE_CHAR;
            PH_FE:   raw_byte = FE_BASE_CHAR + {6'h0, head_job.frame_end};
            PH_CRC:  raw_byte = crc_byte;
            PH_XON:  raw_byte = XON_CHAR;
            default: raw_byte = XON_CHAR;
        endcase
        if (esc_reg) begin
            emit_byte = raw_byte ^ ESC_FLIP;
            step_done = 1'b1;
        end else if ((cur_phase == PH_DATA || cur_phase == PH_CRC) && needs_escape(raw_byte)) begin
            emit_byte = ZDLE_CHAR;
            step_done = 1'b0;
        end else begin
            emit_byte = raw_byte;
            step_done = 1'b1;
        end
        run_end = step_done && (
            (cur_phase == PH_DATA && !head_job.is_last) ||
            (cur_phase == PH_CRC && idx_reg == last_idx && head_job.frame_end != FE_ZCRCW) ||
            (cur_phase == PH_XON));
    end

    // next state
    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        esc_next     = esc_reg;
        m_valid_next = m_valid_reg;
        if (!m_valid_reg || m_ready) begin
            m_valid_next = head_valid;
        end
        if (fire) begin
            esc_next = !step_done;
            if (run_end) begin
                phase_next = PH_DATA;
                idx_next   = 2'd0;
            end else if (step_done) begin
                unique case (cur_phase)
                    PH_DATA: phase_next = PH_ZDLE;
                    PH_ZDLE: phase_next = PH_FE;
                    PH_FE: begin
                        phase_next = PH_CRC;
                        idx_next   = 2'd0;
                    end
                    PH_CRC: begin
                        if (idx_reg == last_idx) begin
                            phase_next = PH_XON;
                        end else begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    default: phase_next = PH_DATA;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_DATA;
            idx_reg     <= 2'd0;
            esc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            esc_reg     <= esc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            byte_reg <= emit_byte;
            last_reg <= run_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;

endmodule

`default_nettype wire

[tb/zmodem_subpacket_encoder_tb.sv]
// zmodem_subpacket_encoder_tb: directed table, then random subpackets in both frame check modes,
// each line byte checked against the table or a local predictor of escaping, trailer and crc
// depends on zsp_pkg and zmodem_subpacket_encoder
`timescale 1ns / 1ps

module zmodem_subpacket_encoder_tb;
    import zsp_pkg::*;

    localparam logic [1:0] FE_ZCRCE = 2'd0;
    localparam logic [1:0] FE_ZCRCG = 2'd1;
    localparam logic [1:0] FE_ZCRCQ = 2'd2;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 20;
    localparam int MAX_REPORTS = 10;
    localparam int DIR_ROWS = 24;
    localparam logic [7:0] ESC_SET [8] = '{8'h10, 8'h11, 8'h13, 8'h18,
                                          8'h90, 8'h91, 8'h93, 8'h98};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last_of_packet;
        logic [1:0] frame_end;
    } sub_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } line_byte_t;

    typedef struct packed {
        logic       cfg_wr;
        logic       cfg_val;
        sub_item_t  item;
        logic       typed;
        logic [1:0] n_typed;
        logic [7:0] b0;
        logic [7:0] b1;
    } dir_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data_byte = 8'h00;
    logic       s_data_valid = 1'b0;
    logic       s_last_of_packet = 1'b0;
    logic [1:0] s_frame_end = FE_ZCRCE;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    // predictor state
    logic        crc32_sel = 1'b0;
    logic [31:0] crc_acc = 32'h0;
    logic        pkt_open = 1'b0;
    logic [7:0]  run_bytes [13];
    int          run_n;
    line_byte_t  line_q [$];

    logic tx_gapless = 1'b0;
    logic hold_req = 1'b0;
    logic hold_on = 1'b0;
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   items_sent = 0;
    int   packets_closed = 0;
    int   bytes_seen = 0;
    int   mode_writes = 0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{1'b0, 1'b0, '{8'h00, 1'b1, 1'b0, FE_ZCRCE}, 1'b1, 2'd1, 8'h00, 8'h00},
        '{1'b0, 1'b0, '{8'hFF, 1'b1, 1'b0, FE_ZCRCW}, 1'b1, 2'd1, 8'hFF, 8'h00},
        '{1'b0, 1'b0, '{8'h10, 1'b1, 1'b0, FE_ZCRCE}, 1'b1, 2'd2, 8'h18, 8'h50},
        '{1'b0, 1'b0, '{8'h11, 1'b1, 1'b0, FE_ZCRCG}, 1'b1, 2'd2, 8'h18, 8'h51},
        '{1'b0, 1'b0, '{8'h13, 1'b1, 1'b0, FE_ZCRCQ}, 1'b1, 2'd2, 8'h18, 8'h53},
        '{1'b0, 1'b0, '{8'h18, 1'b1, 1'b0, FE_ZCRCW}, 1'b1, 2'd2, 8'h18, 8'h58},
        '{1'b0, 1'b0, '{8'h90, 1'b1, 1'b0, FE_ZCRCE}, 1'b1, 2'd2, 8'h18, 8'hD0},
        '{1'b0, 1'b0, '{8'h91, 1'b1, 1'b0, FE_ZCRCE}, 1'b1, 2'd2, 8'h18, 8'hD1},
        '{1'b0, 1'b0, '{8'h93, 1'b1, 1'b0, FE_ZCRCE}, 1'b1, 2'd2, 8'h18, 8'hD3},
        '{1'b0, 1'b0, '{8'h98, 1'b1, 1'b0, FE_ZCRCE}, 1'b1, 2'd2, 8'h18, 8'hD8},
        '{1'b0, 1'b0, '{8'h7F, 1'b1, 1'b0, FE_ZCRCE}, 1'b1, 2'd1, 8'h7F, 8'h00},
        '{1'b0, 1'b0, '{8'hAA, 1'b0, 1'b0, FE_ZCRCW}, 1'b1, 2'd0, 8'h00, 8'h00},
        '{1'b0, 1'b0, '{8'h55, 1'b1, 1'b1, FE_ZCRCE}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 1'b0, '{8'h00, 1'b0, 1'b1, FE_ZCRCG}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 1'b0, '{8'h80, 1'b1, 1'b1, FE_ZCRCQ}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 1'b0, '{8'h01, 1'b1, 1'b1, FE_ZCRCW}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, FE_ZCRCW}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 1'b0, '{8'hFF, 1'b0, 1'b1, FE_ZCRCE}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 1'b0, '{8'hFF, 1'b1, 1'b0, FE_ZCRCE}, 1'b1, 2'd1, 8'hFF, 8'h00},
        '{1'b0, 1'b0, '{8'h18, 1'b1, 1'b1, FE_ZCRCG}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 1'b0, '{8'h7E, 1'b1, 1'b0, FE_ZCRCQ}, 1'b1, 2'd1, 8'h7E, 8'h00},
        // mode flips, the first one while a packet is open
        '{1'b1, 1'b0, '{8'h12, 1'b1, 1'b1, FE_ZCRCQ}, 1'b0, 2'd0, 8'h00, 8'h00},
        '{1'b0, 1'b0, '{8'h33, 1'b0, 1'b0, FE_ZCRCE}, 1'b1, 2'd0, 8'h00, 8'h00},
        '{1'b1, 1'b1, '{8'hA5, 1'b1, 1'b1, FE_ZCRCW}, 1'b0, 2'd0, 8'h00, 8'h00}
    };

    zmodem_subpacket_encoder uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_data_valid     (s_data_valid),
        .s_last_of_packet (s_last_of_packet),
        .s_frame_end      (s_frame_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_last_of_run    (m_last_of_run)
    );

    always #5 aclk = ~aclk;

    function automatic logic [31:0] fold_check(input logic mode32, input logic [31:0] acc,
                                               input logic [7:0] b);
        logic [31:0] c32;
        logic [15:0] c16;
        c32 = acc ^ {24'h0, b};
        c16 = acc[15:0] ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c32 = c32[0] ? ((c32 >> 1) ^ CRC32_POLY) : (c32 >> 1);
            c16 = c16[15] ? ({c16[14:0], 1'b0} ^ CRC16_POLY) : {c16[14:0], 1'b0};
        end
        return mode32 ? c32 : {16'h0, c16};
    endfunction

    function void put_raw(input logic [7:0] b);
        run_bytes[run_n] = b;
        run_n++;
    endfunction

    function void put_line(input logic [7:0] b);
        if (b[6:0] inside {7'h10, 7'h11, 7'h13, 7'h18}) begin
            put_raw(ZDLE_CHAR);
            put_raw(b ^ ESC_FLIP);
        end else begin
            put_raw(b);
        end
    endfunction

    function void predict_encoding(input sub_item_t it);
        logic [7:0]  fe;
        logic [31:0] inv;
        run_n = 0;
        if (!pkt_open) begin
            crc_acc = crc32_sel ? CRC32_INIT : 32'h0;
            pkt_open = 1'b1;
        end
        if (it.data_valid) begin
            put_line(it.data_byte);
            crc_acc = fold_check(crc32_sel, crc_acc, it.data_byte);
        end
        if (it.last_of_packet) begin
            fe = FE_BASE_CHAR + {6'h0, it.frame_end};
            put_raw(ZDLE_CHAR);
            put_raw(fe);
            crc_acc = fold_check(crc32_sel, crc_acc, fe);
            if (crc32_sel) begin
                inv = ~crc_acc;
                for (int k = 0; k < 4; k++) put_line(inv[8*k +: 8]);
            end else begin
                put_line(crc_acc[15:8]);
                put_line(crc_acc[7:0]);
            end
            if (it.frame_end == FE_ZCRCW) put_raw(XON_CHAR);
            pkt_open = 1'b0;
        end
    endfunction

    function void expect_byte(input logic [7:0] b, input logic last);
        line_byte_t lb;
        lb.out_byte = b;
        lb.last_of_run = last;
        line_q.push_back(lb);
    endfunction

    function void report_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) == 0) return ESC_SET[$urandom_range(0, 7)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input sub_item_t it, input logic typed, input logic [1:0] n_typed,
                             input logic [7:0] b0, input logic [7:0] b1);
        int gap;
        gap = tx_gapless ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= it.data_byte;
        s_data_valid <= it.data_valid;
        s_last_of_packet <= it.last_of_packet;
        s_frame_end <= it.frame_end;
        do @(posedge aclk); while (!s_ready);
        predict_encoding(it);
        if (typed) begin
            if (n_typed > 2'd0) expect_byte(b0, n_typed == 2'd1);
            if (n_typed > 2'd1) expect_byte(b1, 1'b1);
        end else begin
            for (int i = 0; i < run_n; i++) expect_byte(run_bytes[i], i == run_n - 1);
        end
        items_sent++;
        if (it.last_of_packet) packets_closed++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (line_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic v);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        crc32_sel = v;
        mode_writes++;
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin : line_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_on = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_on = 1'b0;
                hold_req = 1'b0;
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin : line_check
        line_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            bytes_seen++;
            if (line_q.size() == 0) begin
                report_fail($sformatf("unexpected line byte %02h last %0b",
                                      m_out_byte, m_last_of_run));
            end else begin
                want = line_q.pop_front();
                if (want.out_byte !== m_out_byte)
                    report_fail($sformatf("line byte %0d: out_byte expected %02h got %02h",
                                          bytes_seen, want.out_byte, m_out_byte));
                if (want.last_of_run !== m_last_of_run)
                    report_fail($sformatf("line byte %0d: last_of_run expected %0b got %0b",
                                          bytes_seen, want.last_of_run, m_last_of_run));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("zmodem_subpacket_encoder_tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int counted;
        int plen;
        logic sep_close;
        logic mode;
        sub_item_t it;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].cfg_wr) write_mode(dir_tab[r].cfg_val);
            send_item(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].n_typed,
                      dir_tab[r].b0, dir_tab[r].b1);
        end

        for (int p = 0; p < 4; p++) begin
            mode = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
            write_mode(mode);
            tx_gapless = (p == 2);
            if (p == 1) begin
                hold_req = 1'b1;
                wait (hold_on);
            end
            counted = 0;
            // phase may end with a packet still open, so the next mode write lands mid-packet
            while (counted < PHASE_ITEMS) begin
                plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
                sep_close = (plen == 0) || ($urandom_range(0, 3) == 0);
                for (int k = 0; k < plen && counted < PHASE_ITEMS; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        it.data_byte = rand_byte();
                        it.data_valid = 1'b0;
                        it.last_of_packet = 1'b0;
                        it.frame_end = 2'($urandom_range(0, 3));
                        send_item(it, 1'b0, 2'd0, 8'h00, 8'h00);
                    end
                    it.data_byte = rand_byte();
                    it.data_valid = 1'b1;
                    it.last_of_packet = (k == plen - 1) && !sep_close;
                    it.frame_end = 2'($urandom_range(0, 3));
                    send_item(it, 1'b0, 2'd0, 8'h00, 8'h00);
                    counted++;
                end
                if (sep_close && counted < PHASE_ITEMS) begin
                    it.data_byte = rand_byte();
                    it.data_valid = 1'b0;
                    it.last_of_packet = 1'b1;
                    it.frame_end = 2'($urandom_range(0, 3));
                    send_item(it, 1'b0, 2'd0, 8'h00, 8'h00);
                    counted++;
                end
            end
        end

        settle();
        $display("sent %0d items closing %0d subpackets over %0d mode writes, crc-16 and crc-32",
                 items_sent, packets_closed, mode_writes);
        $display("checked %0d line bytes incl escapes, empty items, empty packets, long stall",
                 bytes_seen);
        if (fail_count == 0 && line_q.size() == 0) begin
            $display("zmodem_subpacket_encoder_tb OK");
        end else begin
            $display("zmodem_subpacket_encoder_tb NOT OK");
        end
        $finish;
    end

endmodule
